>>> hw/rtl/m2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2q_pkg
// Shared widths, types and pivot codes for the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package m2q_pkg;

  localparam int ELEM_W   = 16;
  localparam int FRAC_W   = 14;
  localparam int LANES    = 3;
  localparam int T_W      = ELEM_W + 2;
  localparam int D_W      = ELEM_W + 1;
  localparam int S_W      = ELEM_W + 1;
  localparam int ROOT_W   = 15;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SQ_SHIFT = FRAC_W - 2;
  localparam int NUM_W    = D_W + FRAC_W;
  localparam int Q_W      = 17;
  localparam int REM_W    = ROOT_W + 2;

  localparam logic signed [T_W-1:0] T_ONE     = T_W'(2 ** FRAC_W);
  localparam logic [Q_W-1:0]        Q_POS_MAX = Q_W'(2 ** (ELEM_W - 1) - 1);
  localparam logic [Q_W-1:0]        Q_NEG_MAX = Q_W'(2 ** (ELEM_W - 1));
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = ELEM_W'(2 ** (ELEM_W - 1) - 1);
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = ~ELEM_MAX;

  typedef enum logic [1:0] {PIV_W, PIV_X, PIV_Y, PIV_Z} piv_t;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [D_W-1:0]    diff_t;

  typedef struct packed {
    piv_t                  piv;
    logic [S_W-1:0]        s;
    diff_t [LANES-1:0]     d;
  } pv_t;

  typedef struct packed {
    piv_t                  piv;
    logic [ROOT_W-1:0]     root;
    diff_t [LANES-1:0]     d;
  } rt_t;

  typedef struct packed {
    piv_t                        piv;
    logic [ROOT_W-1:0]           root;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][Q_W-1:0]   q;
  } dq_t;

endpackage

>>> hw/rtl/m2q_pivot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2q_pivot
// Two stages: trace terms and element sums, then pivot choice and radicand.
// ----------------------------------------------------------------------------
module m2q_pivot (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  m2q_pkg::elem_t  e00, e01, e02, e10, e11, e12, e20, e21, e22,
  output logic            out_valid,
  input  logic            out_ready,
  output m2q_pkg::pv_t    out_data
);
  import m2q_pkg::*;

  typedef struct packed {
    logic signed [T_W-1:0] tw, tx, ty, tz;
    diff_t a0, a1, a2, p0, p1, p2;
  } ta_t;

  ta_t  sa, sa_next;
  pv_t  sb, sb_next;
  logic va, vb, rdy_a, rdy_b;

  assign rdy_b    = !vb || out_ready;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;
  assign out_valid = vb;
  assign out_data  = sb;

  always_comb begin
    sa_next.tw = T_W'(e00) + T_W'(e11) + T_W'(e22);
    sa_next.tx = T_W'(e00) - T_W'(e11) - T_W'(e22);
    sa_next.ty = T_W'(e11) - T_W'(e00) - T_W'(e22);
    sa_next.tz = T_W'(e22) - T_W'(e00) - T_W'(e11);
    sa_next.a0 = D_W'(e12) - D_W'(e21);
    sa_next.a1 = D_W'(e20) - D_W'(e02);
    sa_next.a2 = D_W'(e01) - D_W'(e10);
    sa_next.p0 = D_W'(e01) + D_W'(e10);
    sa_next.p1 = D_W'(e20) + D_W'(e02);
    sa_next.p2 = D_W'(e12) + D_W'(e21);
  end

  always_comb begin
    logic signed [T_W-1:0] best;
    logic signed [T_W-1:0] sum;
    piv_t p;
    best = sa.tw;
    p    = PIV_W;
    if (sa.tx > best) begin best = sa.tx; p = PIV_X; end
    if (sa.ty > best) begin best = sa.ty; p = PIV_Y; end
    if (sa.tz > best) begin best = sa.tz; p = PIV_Z; end
    sum = best + T_ONE;
    sb_next.piv = p;
    sb_next.s   = sum[S_W-1:0];
    unique case (p)
      PIV_W: begin sb_next.d[0] = sa.a0; sb_next.d[1] = sa.a1; sb_next.d[2] = sa.a2; end
      PIV_X: begin sb_next.d[0] = sa.p0; sb_next.d[1] = sa.p1; sb_next.d[2] = sa.a0; end
      PIV_Y: begin sb_next.d[0] = sa.p0; sb_next.d[1] = sa.p2; sb_next.d[2] = sa.a1; end
      default: begin sb_next.d[0] = sa.p1; sb_next.d[1] = sa.p2; sb_next.d[2] = sa.a2; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) sa <= sa_next;
    if (rdy_b) sb <= sb_next;
  end

endmodule

>>> hw/rtl/m2q_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2q_sqrt
// Integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module m2q_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  m2q_pkg::pv_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output m2q_pkg::rt_t  out_data
);
  import m2q_pkg::*;

  typedef struct packed {
    piv_t                piv;
    diff_t [LANES-1:0]   d;
    logic [RAD_W-1:0]    rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  function automatic sq_t sq_step(sq_t a);
    sq_t r;
    logic [REM_W+1:0] sh, tr;
    r     = a;
    sh    = {a.rem, a.rad[RAD_W-1 -: 2]};
    tr    = {2'b00, a.root, 2'b01};
    r.rad = a.rad << 2;
    if (sh >= tr) begin
      r.rem  = REM_W'(sh - tr);
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(sh);
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  sq_t               st      [ROOT_W];
  sq_t               st_next [ROOT_W];
  sq_t               seed;
  logic [ROOT_W-1:0] v;
  logic [ROOT_W:0]   rdy;

  always_comb begin
    seed.piv  = in_data.piv;
    seed.d    = in_data.d;
    seed.rad  = {{(RAD_W - S_W - SQ_SHIFT){1'b0}}, in_data.s, {SQ_SHIFT{1'b0}}};
    seed.rem  = '0;
    seed.root = '0;
    st_next[0] = sq_step(seed);
    for (int i = 1; i < ROOT_W; i++) st_next[i] = sq_step(st[i-1]);
  end

  always_comb begin
    rdy[ROOT_W] = out_ready;
    for (int i = ROOT_W - 1; i >= 0; i--) rdy[i] = !v[i] || rdy[i+1];
  end

  assign in_ready      = rdy[0];
  assign out_valid     = v[ROOT_W-1];
  assign out_data.piv  = st[ROOT_W-1].piv;
  assign out_data.root = st[ROOT_W-1].root;
  assign out_data.d    = st[ROOT_W-1].d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < ROOT_W; i++) if (rdy[i]) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ROOT_W; i++) if (rdy[i]) st[i] <= st_next[i];
  end

endmodule

>>> hw/rtl/m2q_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2q_div
// Three-lane rounded divide by 4*root: a numerator set-up stage, then one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module m2q_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  m2q_pkg::rt_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output m2q_pkg::dq_t  out_data
);
  import m2q_pkg::*;

  localparam int NST = Q_W + 1;

  typedef struct packed {
    piv_t                        piv;
    logic [ROOT_W-1:0]           root;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][REM_W-1:0] rem;
    logic [LANES-1:0][Q_W-1:0]   nq;
  } dv_t;

  function automatic dv_t dv_prep(rt_t a);
    dv_t r;
    logic [D_W-1:0]   mag;
    logic [NUM_W-1:0] num;
    r.piv  = a.piv;
    r.root = a.root;
    for (int k = 0; k < LANES; k++) begin
      r.neg[k] = a.d[k][D_W-1];
      mag      = r.neg[k] ? D_W'(-a.d[k]) : D_W'(a.d[k]);
      num      = {mag, {FRAC_W{1'b0}}} + NUM_W'({a.root, 1'b0});
      r.rem[k] = REM_W'(num[NUM_W-1:Q_W]);
      r.nq[k]  = num[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t a);
    dv_t r;
    logic [REM_W:0] sh, den;
    r   = a;
    den = {1'b0, a.root, 2'b00};
    for (int k = 0; k < LANES; k++) begin
      sh = {a.rem[k], a.nq[k][Q_W-1]};
      if (sh >= den) begin
        r.rem[k] = REM_W'(sh - den);
        r.nq[k]  = {a.nq[k][Q_W-2:0], 1'b1};
      end else begin
        r.rem[k] = REM_W'(sh);
        r.nq[k]  = {a.nq[k][Q_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  dv_t            st      [NST];
  dv_t            st_next [NST];
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  always_comb begin
    st_next[0] = dv_prep(in_data);
    for (int i = 1; i < NST; i++) st_next[i] = dv_step(st[i-1]);
  end

  always_comb begin
    rdy[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !v[i] || rdy[i+1];
  end

  assign in_ready      = rdy[0];
  assign out_valid     = v[NST-1];
  assign out_data.piv  = st[NST-1].piv;
  assign out_data.root = st[NST-1].root;
  assign out_data.neg  = st[NST-1].neg;
  assign out_data.q    = st[NST-1].nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) if (rdy[i]) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) if (rdy[i]) st[i] <= st_next[i];
  end

endmodule

>>> hw/rtl/m2q_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2q_out
// Sign, saturation and component placement into the output register.
// ----------------------------------------------------------------------------
module m2q_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  m2q_pkg::dq_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output m2q_pkg::elem_t  qx,
  output m2q_pkg::elem_t  qy,
  output m2q_pkg::elem_t  qz,
  output m2q_pkg::elem_t  qw,
  output logic [1:0]      pivot
);
  import m2q_pkg::*;

  elem_t lane [LANES];
  elem_t big;
  elem_t qx_next, qy_next, qz_next, qw_next;

  assign in_ready = !out_valid || out_ready;
  assign big      = ELEM_W'({1'b0, in_data.root});

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (in_data.neg[k]) begin
        lane[k] = (in_data.q[k] > Q_NEG_MAX) ? ELEM_MIN
                                             : ELEM_W'(-$signed({1'b0, in_data.q[k]}));
      end else begin
        lane[k] = (in_data.q[k] > Q_POS_MAX) ? ELEM_MAX : ELEM_W'(in_data.q[k]);
      end
    end
    unique case (in_data.piv)
      PIV_W: begin
        qx_next = lane[0]; qy_next = lane[1]; qz_next = lane[2]; qw_next = big;
      end
      PIV_X: begin
        qx_next = big; qy_next = lane[0]; qz_next = lane[1]; qw_next = lane[2];
      end
      PIV_Y: begin
        qx_next = lane[0]; qy_next = big; qz_next = lane[1]; qw_next = lane[2];
      end
      default: begin
        qx_next = lane[0]; qy_next = lane[1]; qz_next = big; qw_next = lane[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      qx    <= qx_next;
      qy    <= qy_next;
      qz    <= qz_next;
      qw    <= qw_next;
      pivot <= in_data.piv;
    end
  end

endmodule

>>> hw/rtl/matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_to_quaternion
// Rotation matrix (Q2.14) to unit quaternion by the largest-component method.
// ----------------------------------------------------------------------------
// Fully pipelined: one matrix is taken every cycle while the output does not
// stall; it passes 2 pivot stages, 15 square-root stages at one root bit each,
// 18 divider stages (numerator set-up, then one quotient bit each), 1 output
// register. Every stage holds its item under back-pressure and empty stages
// close up, so stalls on the output lose and repeat nothing.
module matrix_to_quaternion (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  m2q_pkg::elem_t  e00, e01, e02, e10, e11, e12, e20, e21, e22,
  output logic            out_valid,
  input  logic            out_ready,
  output m2q_pkg::elem_t  qx,
  output m2q_pkg::elem_t  qy,
  output m2q_pkg::elem_t  qz,
  output m2q_pkg::elem_t  qw,
  output logic [1:0]      pivot
);
  import m2q_pkg::*;

  pv_t  pv_data;
  rt_t  rt_data;
  dq_t  dq_data;
  logic pv_valid, pv_ready, rt_valid, rt_ready, dq_valid, dq_ready;

  m2q_pivot u_pivot (
    .clk, .rst, .in_valid, .in_ready,
    .e00, .e01, .e02, .e10, .e11, .e12, .e20, .e21, .e22,
    .out_valid(pv_valid), .out_ready(pv_ready), .out_data(pv_data)
  );

  m2q_sqrt u_sqrt (
    .clk, .rst,
    .in_valid(pv_valid), .in_ready(pv_ready), .in_data(pv_data),
    .out_valid(rt_valid), .out_ready(rt_ready), .out_data(rt_data)
  );

  m2q_div u_div (
    .clk, .rst,
    .in_valid(rt_valid), .in_ready(rt_ready), .in_data(rt_data),
    .out_valid(dq_valid), .out_ready(dq_ready), .out_data(dq_data)
  );

  m2q_out u_out (
    .clk, .rst,
    .in_valid(dq_valid), .in_ready(dq_ready), .in_data(dq_data),
    .out_valid, .out_ready, .qx, .qy, .qz, .qw, .pivot
  );

endmodule

>>> hw/rtl/m2q_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2q_checker
// Port-level checks for matrix_to_quaternion, bound to the top level.
// ----------------------------------------------------------------------------
module m2q_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input m2q_pkg::elem_t  qx,
  input m2q_pkg::elem_t  qy,
  input m2q_pkg::elem_t  qz,
  input m2q_pkg::elem_t  qw,
  input logic [1:0]      pivot
);
  import m2q_pkg::*;

  localparam logic signed [ELEM_W-1:0] PIV_MIN = ELEM_W'(2 ** (FRAC_W - 1));

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(qx) && $stable(qy)
      && $stable(qz) && $stable(qw) && $stable(pivot))
    else $error("output item changed while stalled");

  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_piv_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pivot == PIV_W && qw >= PIV_MIN) || (pivot == PIV_X && qx >= PIV_MIN)
      || (pivot == PIV_Y && qy >= PIV_MIN) || (pivot == PIV_Z && qz >= PIV_MIN))
    else $error("pivot component below one half");

  a_piv_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && pivot == PIV_W |-> !qw[ELEM_W-1])
    else $error("w pivot component negative");

endmodule

bind matrix_to_quaternion m2q_checker u_m2q_checker (
  .clk, .rst, .out_valid, .out_ready, .qx, .qy, .qz, .qw, .pivot
);
